### hw/rtl/spfb_pkg.sv
// shared types, register indexes and bf16/fp32 helpers for the same-padded fir
package spfb_pkg;

    typedef struct packed {
        logic [15:0] sample;
        logic        last_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic        last_out;
    } out_item_t;

    localparam logic [2:0] REG_TAPS_LOW  = 3'd0;
    localparam logic [2:0] REG_TAPS_HIGH = 3'd1;
    localparam logic [2:0] REG_TAP8_BIAS = 3'd2;
    localparam logic [2:0] REG_TAP_COUNT = 3'd3;
    localparam logic [2:0] REG_BIAS_EN   = 3'd4;
    localparam logic [2:0] REG_OUT_F32   = 3'd5;

    localparam logic [3:0] MAX_TAPS = 4'd9;

    localparam int WIN_DEPTH = 9;

    // one output job: 9-deep sample history, lag and last flag
    typedef struct packed {
        logic [WIN_DEPTH*16-1:0] hist;
        logic [3:0]              lag;
        logic                    last_out;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_ADD,
        BK_OUT
    } back_state_t;

    // product of two bf16 values as fp32; exact unless it overflows or lands in the subnormal range
    function automatic logic [31:0] bf_mul(input logic [15:0] a, input logic [15:0] b);
        logic        s;
        logic [7:0]  ea, eb;
        logic [7:0]  ma, mb;
        logic [15:0] p;
        logic signed [10:0] e;
        logic [31:0] r;
        logic [4:0]  lz;
        logic [47:0] m;
        logic [5:0]  sh;
        logic [63:0] w;
        logic [24:0] q;
        s  = a[15] ^ b[15];
        ea = a[14:7];
        eb = b[14:7];
        ma = {ea != 8'd0, a[6:0]};
        mb = {eb != 8'd0, b[6:0]};
        r  = {s, 31'd0};
        if ((ea == 8'hFF && a[6:0] != 0) || (eb == 8'hFF && b[6:0] != 0)) begin
            r = 32'h7FC00000;
        end else if (ea == 8'hFF || eb == 8'hFF) begin
            if ((ea == 8'hFF && b[14:0] == 0) || (eb == 8'hFF && a[14:0] == 0))
                r = 32'h7FC00000;
            else
                r = {s, 8'hFF, 23'd0};
        end else begin
            p = ma * mb;
            if (p != 16'd0) begin
                lz = 5'd0;
                for (int i = 15; i >= 0; i--) begin
                    if (p[i] && lz == 5'd0) lz = 5'(16 - i);
                end
                // value = p * 2^(ea'+eb'-268), ea' = max(ea,1)
                e = 11'(ea == 0 ? 1 : ea) + 11'(eb == 0 ? 1 : eb) - 11'sd125
                    - 11'(lz);
                m = {p, 32'd0} << lz; // leading one shifted out
                if (e >= 11'sd255) begin
                    r = {s, 8'hFF, 23'd0};
                end else if (e >= 11'sd1) begin
                    r = {s, e[7:0], m[47:25]};
                end else if (e < -11'sd23) begin
                    // below half the smallest subnormal
                    r = {s, 31'd0};
                end else begin
                    // subnormal: shift in the hidden one, round to nearest even
                    sh = 6'(11'sd1 - e);
                    w  = {1'b1, m[47:25], 40'd0} >> sh;
                    q  = {1'b0, w[63:40]};
                    if (w[39] && (w[38:0] != 0 || w[40])) q = q + 25'd1;
                    r = {s, 7'd0, q[23:0]};
                end
            end
        end
        return r;
    endfunction

    // fp32 add, round to nearest even, subnormals kept
    function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea, eb, el;
        logic [26:0] ma, mb, t;
        logic [27:0] sum;
        logic        sa, sb, so, st;
        logic [31:0] r, x, y;
        logic [8:0]  d;
        logic [9:0]  e;
        logic [4:0]  lz;
        logic [24:0] mr;
        x = a; y = b;
        if (a[30:0] < b[30:0]) begin x = b; y = a; end
        sa = x[31]; sb = y[31];
        ea = x[30:23]; eb = y[30:23];
        if ((ea == 8'hFF && x[22:0] != 0) || (eb == 8'hFF && y[22:0] != 0)) begin
            r = 32'h7FC00000;
        end else if (ea == 8'hFF) begin
            r = (eb == 8'hFF && sa != sb) ? 32'h7FC00000 : x;
        end else if (x[30:0] == 0) begin
            r = {sa & sb, 31'd0};
        end else begin
            ma = {ea != 0, x[22:0], 3'b000};
            mb = {eb != 0, y[22:0], 3'b000};
            el = (ea == 0) ? 8'd1 : ea;
            d = 9'(el) - 9'((eb == 0) ? 8'd1 : eb);
            if (d > 9'd26) begin
                mb = {26'd0, mb != 0};
            end else begin
                t  = mb >> d;
                st = (mb & ((27'd1 << d) - 27'd1)) != 0;
                mb = {t[26:1], t[0] | st};
            end
            if (sa == sb) sum = {1'b0, ma} + {1'b0, mb};
            else          sum = {1'b0, ma} - {1'b0, mb};
            so = sa;
            e  = {2'b0, el};
            if (sum == 0) begin
                r = 32'd0;
            end else begin
                if (sum[27]) begin
                    sum = {1'b0, sum[27:2], sum[1] | sum[0]};
                    e = e + 10'd1;
                end else begin
                    // highest set bit wins
                    lz = 5'd0;
                    for (int i = 0; i <= 26; i++) begin
                        if (sum[i]) lz = 5'(26 - i);
                    end
                    if ({5'd0, lz} >= e) lz = 5'(e - 10'd1);
                    sum = sum << lz;
                    e = e - 10'(lz);
                    if (!sum[26]) e = 10'd0;
                end
                mr = {1'b0, sum[26:3]};
                if (sum[2] && (sum[1] | sum[0] | sum[3])) mr = mr + 25'd1;
                if (mr[24]) begin
                    mr = mr >> 1; e = e + 10'd1;
                end else if (e == 10'd0 && mr[23]) begin
                    e = 10'd1;
                end
                if (e >= 10'd255) r = {so, 8'hFF, 23'd0};
                else              r = {so, e[7:0], mr[22:0]};
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/spfb_front.sv
// front end: sample window, output scheduling and job generation
module spfb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  spfb_pkg::in_item_t   s_data,
    input  logic [3:0]           eff_k,
    output logic                 job_valid,
    input  logic                 job_ready,
    output spfb_pkg::job_t       job
);
    logic [127:0] win_reg, win_next;
    logic [2:0]   seen_reg, seen_next;
    logic         busy_reg, busy_next;
    logic [143:0] hist_reg, hist_next;
    logic         last_reg, last_next;
    logic [3:0]   lag_reg, lag_next;
    logic         first_reg, first_next;
    logic [2:0]   sseen_reg, sseen_next;
    logic [2:0]   pad;
    logic         emit;

    assign pad = eff_k[3:1];
    assign s_ready = !busy_reg;

    // first job: lag = pad when seen >= pad; then lags pad-1 .. 0 (<= seen) on last
    always_comb begin
        emit = 1'b0;
        if (busy_reg) begin
            if (first_reg) emit = ({1'b0, sseen_reg} >= {1'b0, pad});
            else           emit = (lag_reg <= {1'b0, sseen_reg});
        end
    end

    always_comb begin
        logic more;
        logic [3:0] nl;
        win_next = win_reg; seen_next = seen_reg; busy_next = busy_reg;
        hist_next = hist_reg; last_next = last_reg; lag_next = lag_reg;
        first_next = first_reg; sseen_next = sseen_reg;
        nl = first_reg ? {1'b0, pad} : lag_reg;
        more = last_reg && nl != 4'd0;
        job_valid = emit;
        job.hist = hist_reg;
        job.lag  = nl;
        job.last_out = 1'b0;
        // last flag: no later emitted lag exists
        if (last_reg) begin
            job.last_out = 1'b1;
            for (int l = 0; l < 8; l++) begin
                if (4'(l) < nl && 3'(l) <= sseen_reg) job.last_out = 1'b0;
            end
        end
        if (!busy_reg && s_valid) begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            hist_next  = {win_reg, s_data.sample};
            last_next  = s_data.last_in;
            sseen_next = seen_reg;
            if (s_data.last_in) begin
                win_next = '0; seen_next = 3'd0;
            end else begin
                win_next = {win_reg[111:0], s_data.sample};
                if (seen_reg != 3'd7) seen_next = seen_reg + 3'd1;
            end
        end else if (busy_reg && (!emit || job_ready)) begin
            first_next = 1'b0;
            if (more) lag_next = nl - 4'd1;
            else      busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0; seen_reg <= '0; busy_reg <= 1'b0;
            first_reg <= 1'b0; lag_reg <= '0; last_reg <= 1'b0; sseen_reg <= '0;
        end else begin
            win_reg <= win_next; seen_reg <= seen_next; busy_reg <= busy_next;
            first_reg <= first_next; lag_reg <= lag_next; last_reg <= last_next;
            sseen_reg <= sseen_next;
        end
        hist_reg <= hist_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> busy_reg) else $error("job outside busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid |-> job.lag <= 4'd4) else $error("lag beyond pad");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && !job_ready) |=> job_valid) else $error("job dropped");
endmodule

### hw/rtl/spfb_queue.sv
// two-entry job queue between front and back
module spfb_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  spfb_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output spfb_pkg::job_t out_job
);
    spfb_pkg::job_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;
    logic           wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_job   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= in_job;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (wr && !rd) |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count slip");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> wp_reg == rp_reg) else $error("pointer mismatch");
endmodule

### hw/rtl/spfb_back.sv
// back end: shared multiply then add per tap, output packing
module spfb_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  spfb_pkg::job_t            job,
    input  logic [143:0]              taps,
    input  logic [15:0]               bias,
    input  logic                      bias_en,
    input  logic                      out_f32,
    input  logic [3:0]                eff_k,
    output logic                      m_valid,
    input  logic                      m_ready,
    output spfb_pkg::out_item_t       m_data
);
    spfb_pkg::back_state_t st_reg, st_next;
    spfb_pkg::job_t job_reg, job_next;
    logic [31:0] acc_reg, acc_next, prod_reg, prod_next;
    logic [3:0]  p_reg, p_next;
    logic [31:0] res;
    logic        nan;
    logic signed [5:0] d;
    logic [15:0] smp, tap;

    assign d   = 6'(job_reg.lag) + 6'(eff_k[3:1]) - 6'(p_reg);
    assign smp = (d >= 0 && d <= 6'sd8) ? job_reg.hist[d[3:0]*16 +: 16] : 16'd0;
    assign tap = taps[p_reg*16 +: 16];
    assign nan = acc_reg[30:23] == 8'hFF && acc_reg[22:0] != 0;
    always_comb begin
        logic [31:0] rb;
        rb  = (acc_reg + 32'h7FFF + {31'd0, acc_reg[16]}) >> 16;
        res = out_f32 ? (nan ? 32'h7FC00000 : acc_reg)
                      : (nan ? 32'h00007FC0 : {16'd0, rb[15:0]});
    end

    always_comb begin
        st_next = st_reg; job_next = job_reg; acc_next = acc_reg;
        prod_next = prod_reg; p_next = p_reg;
        job_ready = 1'b0;
        m_valid = 1'b0;
        m_data.result_value = res;
        m_data.last_out = job_reg.last_out;
        case (st_reg)
            spfb_pkg::BK_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    job_next = job;
                    acc_next = bias_en ? {bias, 16'd0} : 32'd0;
                    p_next = 4'd0;
                    st_next = spfb_pkg::BK_MUL;
                end
            end
            spfb_pkg::BK_MUL: begin
                prod_next = spfb_pkg::bf_mul(tap, smp);
                st_next = spfb_pkg::BK_ADD;
            end
            spfb_pkg::BK_ADD: begin
                acc_next = spfb_pkg::f_add(acc_reg, prod_reg);
                p_next = p_reg + 4'd1;
                st_next = (p_reg + 4'd1 >= eff_k) ? spfb_pkg::BK_OUT : spfb_pkg::BK_MUL;
            end
            spfb_pkg::BK_OUT: begin
                m_valid = 1'b1;
                if (m_ready) st_next = spfb_pkg::BK_IDLE;
            end
            default: st_next = spfb_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= spfb_pkg::BK_IDLE;
        else          st_reg <= st_next;
        job_reg <= job_next; acc_reg <= acc_next;
        prod_reg <= prod_next; p_reg <= p_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> st_reg == spfb_pkg::BK_OUT) else $error("result outside out state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == spfb_pkg::BK_MUL) |-> p_reg < 4'd9) else $error("tap index range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(acc_reg)) else $error("result changed");
endmodule

### hw/rtl/same_padded_fir_bf16_unit.sv
// top level of the same-padded bf16 fir: config registers, front, queue, back
// usage:
//   s_ channel takes one bf16 sample a beat, with last_in on the channel's end
//   m_ channel gives result beats, bf16 in bits 15:0 or fp32, last_out on the
//   final one; outputs lag input by pad = (taps-1)/2 samples, flushed on last
//   cfg channel writes register cfg_index with cfg_data; the user must write
//   only while idle, which the block itself does not enforce
// schedule:
//   each output steps through load, a multiply and add per tap, then present,
//   set by the single shared multiply/add unit in back
//   the front takes no new sample until it has emitted that sample's jobs,
//   with the flushed lags on a last sample; a two-entry job queue decouples
//   it from the back end
// reset: aresetn low clears window, counters, queue; taps and bias go to
//   zero, tap count to nine, bias on, bf16 output
// stall: when m_ready is low the back holds its result, the queue fills and
//   then the front stops taking samples
module same_padded_fir_bf16_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  spfb_pkg::in_item_t      s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output spfb_pkg::out_item_t     m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [63:0]             cfg_data
);
    logic [63:0] taps_low_reg, taps_high_reg;
    logic [31:0] tap8_bias_reg;
    logic [3:0]  tap_count_reg;
    logic        bias_en_reg, out_f32_reg;
    logic [3:0]  eff_k;

    // config writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_low_reg <= '0; taps_high_reg <= '0; tap8_bias_reg <= '0;
            tap_count_reg <= 4'd9; bias_en_reg <= 1'b1; out_f32_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                spfb_pkg::REG_TAPS_LOW:  taps_low_reg  <= cfg_data;
                spfb_pkg::REG_TAPS_HIGH: taps_high_reg <= cfg_data;
                spfb_pkg::REG_TAP8_BIAS: tap8_bias_reg <= cfg_data[31:0];
                spfb_pkg::REG_TAP_COUNT: tap_count_reg <= cfg_data[3:0];
                spfb_pkg::REG_BIAS_EN:   bias_en_reg   <= cfg_data[0];
                spfb_pkg::REG_OUT_F32:   out_f32_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective odd tap count, clamped to 1..MAX_TAPS
    always_comb begin
        eff_k = tap_count_reg;
        if (eff_k > spfb_pkg::MAX_TAPS) eff_k = spfb_pkg::MAX_TAPS;
        if (eff_k == 4'd0) eff_k = 4'd1;
        if (!eff_k[0]) eff_k = eff_k - 4'd1;
    end

    logic           fj_valid, fj_ready, bj_valid, bj_ready;
    spfb_pkg::job_t fj, bj;

    spfb_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .eff_k,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    spfb_queue u_queue (
        .aclk, .aresetn,
        .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fj),
        .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bj)
    );

    spfb_back u_back (
        .aclk, .aresetn,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .taps({tap8_bias_reg[15:0], taps_high_reg, taps_low_reg}),
        .bias(tap8_bias_reg[31:16]), .bias_en(bias_en_reg), .out_f32(out_f32_reg),
        .eff_k, .m_valid, .m_ready, .m_data
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        eff_k[0] && eff_k <= spfb_pkg::MAX_TAPS) else $error("tap count not odd in range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result withdrawn");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data)) else $error("result changed while stalled");
endmodule
